// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the embedder RTL.
// Every property is sampled on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check.
`define ASSERT_PROP(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Condition that must never be true at a clock edge.
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`endif

// File: src/dce_pkg.sv
// ----------------------------------------------------------------------------
// dce_pkg
// Types and constants shared by the DCT coefficient LSB embedder.
// ----------------------------------------------------------------------------
package dce_pkg;

  // Message store geometry.
  localparam int MsgDepth = 4096;
  localparam int MsgAw    = $clog2(MsgDepth);

  // Stream layout: a 32-bit length header, then the bytes.
  localparam int HdrBits  = 32;
  localparam int LenW     = 13;
  localparam int PtrW     = 16;

  // Queue between the front and back parts.
  localparam int QDepth   = 4;
  localparam int QAw      = $clog2(QDepth);
  localparam int QCw      = QAw + 1;

  // Request codes; code 3 has no meaning and is ignored.
  typedef enum logic [1:0] {
    ReqLoad    = 2'd0,
    ReqCoef    = 2'd1,
    ReqRestart = 2'd2
  } req_type_e;

  // One input beat.
  typedef struct packed {
    req_type_e          req_type;
    logic [11:0]        msg_addr;
    logic [7:0]         msg_byte;
    logic [5:0]         coef_pos;
    logic signed [15:0] coef_value;
  } req_t;

  // One result beat.
  typedef struct packed {
    logic signed [15:0] coef_out;
    logic               bit_embedded;
    logic               embed_done;
  } rsp_t;

  // Classified coefficient waiting in the queue.
  typedef struct packed {
    logic signed [15:0] coef;
    logic               embedded;
    logic               done;
    logic               from_hdr;
    logic               hdr_bit;
    logic [7:0]         msg_byte;
    logic [2:0]         bit_idx;
  } entry_t;

endpackage

// File: src/dce_ram.sv
// ----------------------------------------------------------------------------
// dce_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dce_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: src/dce_front.sv
// ----------------------------------------------------------------------------
// dce_front
// Accepts requests, keeps the bit pointer and done flag, writes and reads the
// message store, and hands classified coefficients to the queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dce_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  dce_pkg::req_t                req_i,
  input  logic                         cfg_we_i,
  input  logic [dce_pkg::LenW-1:0]     cfg_data_i,
  output logic                         push_o,
  output dce_pkg::entry_t              entry_o
);
  import dce_pkg::*;

  logic [PtrW-1:0] ptr_q, ptr_d;
  logic            fin_q, fin_d;
  logic [LenW-1:0] len_q;
  logic [PtrW-1:0] total;
  logic [PtrW-1:0] byte_bit;
  logic [31:0]     hdr_word;
  logic            is_coef;
  logic            cand;
  logic            emb;
  logic            set_fin;
  logic            from_hdr;
  logic            ram_we;
  logic            ram_re;
  logic [7:0]      ram_rdata;

  logic               s_valid_q;
  logic signed [15:0] s_coef_q;
  logic               s_emb_q;
  logic               s_done_q;
  logic               s_hdr_q;
  logic               s_hdr_bit_q;
  logic [2:0]         s_bidx_q;

  // Saturated message length, captured on a configuration write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (cfg_we_i) begin
      len_q <= (cfg_data_i > LenW'(MsgDepth)) ? LenW'(MsgDepth) : cfg_data_i;
    end
  end

  // Stream length in bits and the header word.
  assign total    = PtrW'(HdrBits) + {len_q, 3'b000};
  assign hdr_word = {{(32 - LenW){1'b0}}, len_q};
  assign byte_bit = ptr_q - PtrW'(HdrBits);
  assign from_hdr = ptr_q < PtrW'(HdrBits);

  // Classify the incoming coefficient.
  always_comb begin
    is_coef = accept_i && (req_i.req_type == ReqCoef);
    cand    = !fin_q && (req_i.coef_pos != '0) && (req_i.coef_value != '0);
    emb     = is_coef && cand && (ptr_q < total);
    set_fin = is_coef && cand && !(ptr_q < total);
  end

  // Pointer and done flag update.
  always_comb begin
    ptr_d = ptr_q;
    fin_d = fin_q;
    if (accept_i) begin
      case (req_i.req_type)
        ReqCoef: begin
          if (emb) begin
            ptr_d = ptr_q + PtrW'(1);
          end
          if (set_fin) begin
            fin_d = 1'b1;
          end
        end
        ReqRestart: begin
          ptr_d = '0;
          fin_d = 1'b0;
        end
        default: begin
          ptr_d = ptr_q;
          fin_d = fin_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      fin_q <= 1'b0;
    end else begin
      ptr_q <= ptr_d;
      fin_q <= fin_d;
    end
  end

  // Message store: loads write it, embedded payload bits read it.
  assign ram_we = accept_i && (req_i.req_type == ReqLoad)
                  && ({1'b0, req_i.msg_addr} < 13'(MsgDepth));
  assign ram_re = emb && !from_hdr;

  dce_ram #(
    .Width (8),
    .Depth (MsgDepth)
  ) u_msg_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (req_i.msg_addr[MsgAw-1:0]),
    .wdata_i (req_i.msg_byte),
    .re_i    (ram_re),
    .raddr_i (byte_bit[MsgAw+2:3]),
    .rdata_o (ram_rdata)
  );

  // Stage register that lines up with the store's read data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else begin
      s_valid_q <= is_coef;
    end
  end

  // The header is sent MSB first, so bit index 31 - ptr is the inverted pointer.
  always_ff @(posedge clk_i) begin
    if (is_coef) begin
      s_coef_q    <= req_i.coef_value;
      s_emb_q     <= emb;
      s_done_q    <= fin_q | set_fin;
      s_hdr_q     <= from_hdr;
      s_hdr_bit_q <= hdr_word[~ptr_q[4:0]];
      s_bidx_q    <= ptr_q[2:0];
    end
  end

  assign push_o            = s_valid_q;
  assign entry_o.coef      = s_coef_q;
  assign entry_o.embedded  = s_emb_q;
  assign entry_o.done      = s_done_q;
  assign entry_o.from_hdr  = s_hdr_q;
  assign entry_o.hdr_bit   = s_hdr_bit_q;
  assign entry_o.msg_byte  = ram_rdata;
  assign entry_o.bit_idx   = s_bidx_q;

  // A coefficient that carries a bit can never also report the done flag.
  `ASSERT_PROP(a_emb_not_done, s_valid_q && s_emb_q |-> !s_done_q)
  // The done flag only rises from an accepted coefficient.
  `ASSERT_PROP(a_fin_rise, $rose(fin_q) |-> $past(accept_i && req_i.req_type == ReqCoef))

endmodule

// File: src/dce_queue.sv
// ----------------------------------------------------------------------------
// dce_queue
// Short register queue between the front and back parts.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dce_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  dce_pkg::entry_t           entry_i,
  input  logic                      pop_i,
  output dce_pkg::entry_t           entry_o,
  output logic                      empty_o,
  output logic [dce_pkg::QCw-1:0]   count_o
);
  import dce_pkg::*;

  entry_t         slots_q [QDepth];
  logic [QAw-1:0] wr_q;
  logic [QAw-1:0] rd_q;
  logic [QCw-1:0] count_q;
  logic           do_pop;

  assign empty_o = (count_q == '0);
  assign do_pop  = pop_i && !empty_o;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QAw'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QAw'(1);
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + QCw'(1);
      end else if (do_pop && !push_i) begin
        count_q <= count_q - QCw'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= entry_i;
    end
  end

  assign entry_o = slots_q[rd_q];
  assign count_o = count_q;

  // The front never pushes into a full queue.
  `ASSERT_NEVER(a_no_overflow, push_i && (count_q == QCw'(QDepth)))

endmodule

// File: src/dce_back.sv
// ----------------------------------------------------------------------------
// dce_back
// Picks the stream bit for the queue head and forms the result beat.
// ----------------------------------------------------------------------------
module dce_back (
  input  dce_pkg::entry_t entry_i,
  output dce_pkg::rsp_t   rsp_o
);
  import dce_pkg::*;

  logic stream_bit;

  // Header bit, or message byte bit taken MSB first.
  always_comb begin
    if (entry_i.from_hdr) begin
      stream_bit = entry_i.hdr_bit;
    end else begin
      stream_bit = entry_i.msg_byte[~entry_i.bit_idx];
    end
  end

  // Replace the LSB only when the coefficient carries a bit.
  always_comb begin
    rsp_o.coef_out     = entry_i.embedded ? {entry_i.coef[15:1], stream_bit}
                                          : entry_i.coef;
    rsp_o.bit_embedded = entry_i.embedded;
    rsp_o.embed_done   = entry_i.done;
  end

endmodule

// File: src/dct_coefficient_lsb_embedder.sv
// ----------------------------------------------------------------------------
// dct_coefficient_lsb_embedder
// Hides a message in the LSBs of nonzero AC quantized DCT coefficients.
// ----------------------------------------------------------------------------
// Input side is a queue write port: a beat is taken when push is high and
// full is low. Load beats write the 4096-byte message store, restart beats
// clear the bit pointer and done flag, coefficient beats produce exactly one
// result; other codes are dropped. Result side is a queue read port: the
// oldest result sits on rsp_o while empty is low and is taken when pop is high.
// The length register is written through cfg_valid_i/cfg_data_i; cfg_ready_o
// is always high. Write it only while the block is idle.
// A coefficient that is taken passes the stage register, which holds the store
// read, then the queue, from whose head it reaches rsp_o and is popped.
// Throughput: one beat per cycle while full is low, set by the pointer update
// and the one read port of the message store.
// Reset clears the pointer, done flag, length register and queue; the store
// is undefined until loaded. When the receiver stalls, results collect in a
// four-entry queue and full rises once queue and stage hold four beats.
// ----------------------------------------------------------------------------
module dct_coefficient_lsb_embedder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  dce_pkg::req_t                req_i,
  output logic                         empty,
  input  logic                         pop,
  output dce_pkg::rsp_t                rsp_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [dce_pkg::LenW-1:0]     cfg_data_i
);
  import dce_pkg::*;

  logic           accept;
  logic           stage_push;
  entry_t         stage_entry;
  entry_t         head_entry;
  logic [QCw-1:0] q_count;
  logic [QCw:0]   occupancy;

  // Room is reserved for the beat still in the front stage.
  assign occupancy   = {1'b0, q_count} + {{QCw{1'b0}}, stage_push};
  assign full        = occupancy >= (QCw + 1)'(QDepth);
  assign accept      = push && !full;
  assign cfg_ready_o = 1'b1;

  dce_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .req_i      (req_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .push_o     (stage_push),
    .entry_o    (stage_entry)
  );

  dce_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (stage_push),
    .entry_i (stage_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .empty_o (empty),
    .count_o (q_count)
  );

  dce_back u_back (
    .entry_i (head_entry),
    .rsp_o   (rsp_o)
  );

endmodule

// File: tb/tb_dct_coefficient_lsb_embedder.sv
// ----------------------------------------------------------------------------
// tb_dct_coefficient_lsb_embedder
// Self-checking bench for the DCT coefficient LSB embedder. A tracker class
// keeps its own copy of the message store, bit pointer, done flag and length
// register, and predicts one result beat for every coefficient beat taken.
// The sender pushes bursts with random gaps, the receiver pops on a changing
// stall pattern, and each result beat is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_dct_coefficient_lsb_embedder;
  import dce_pkg::*;

  // Request code with no meaning; the block must drop it.
  localparam logic [1:0] ReqUnused = 2'd3;

  localparam int ItemTarget  = 1750;
  localparam int NumPhases   = 10;
  localparam int IdleCycles  = 4;
  localparam int DrainCycles = 10;
  localparam int DrainLimit  = 5000;
  localparam int MaxPrinted  = 40;

  // Tracks the embedding state and holds the result beats still to come.
  class lsb_embed_tracker;
    logic [7:0]  msg_mem [MsgDepth];
    bit          loaded  [MsgDepth];
    int unsigned bit_ptr;
    bit          done;
    int unsigned msg_len;
    rsp_t        expected_coefs [$];
    int          errors;

    function new();
      bit_ptr = 0;
      done    = 1'b0;
      msg_len = 0;
      errors  = 0;
      foreach (loaded[i]) loaded[i] = 1'b0;
    endfunction

    task report_mismatch(string what);
      // Keep the log short when the block is badly off.
      if (errors < MaxPrinted) $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    function void set_length(logic [LenW-1:0] len);
      msg_len = len;
    endfunction

    // Lengths above the store size saturate, for the header and the count.
    function int unsigned eff_len();
      return (msg_len > MsgDepth) ? MsgDepth : msg_len;
    endfunction

    function int pending();
      return expected_coefs.size();
    endfunction

    // Byte the next embedded bit would read, if it was never loaded.
    function int unloaded_byte();
      int unsigned addr;
      if (done || bit_ptr < HdrBits || bit_ptr >= HdrBits + 8 * eff_len()) return -1;
      addr = (bit_ptr - HdrBits) >> 3;
      return loaded[addr] ? -1 : int'(addr);
    endfunction

    // Apply one accepted input beat and queue the result it causes.
    function void note_input(req_t r);
      rsp_t        exp_rsp;
      int unsigned eff;
      int unsigned idx;
      logic [31:0] hdr;
      logic [7:0]  cur_byte;
      case (r.req_type)
        ReqLoad: begin
          msg_mem[r.msg_addr] = r.msg_byte;
          loaded[r.msg_addr]  = 1'b1;
        end
        ReqRestart: begin
          bit_ptr = 0;
          done    = 1'b0;
        end
        ReqCoef: begin
          exp_rsp.coef_out     = r.coef_value;
          exp_rsp.bit_embedded = 1'b0;
          // DC and zero coefficients never carry a bit.
          if (!done && r.coef_pos != '0 && r.coef_value != '0) begin
            eff = eff_len();
            if (bit_ptr < HdrBits + 8 * eff) begin
              if (bit_ptr < HdrBits) begin
                hdr = eff;
                exp_rsp.coef_out[0] = hdr[31 - bit_ptr];
              end else begin
                idx      = bit_ptr - HdrBits;
                cur_byte = msg_mem[idx >> 3];
                exp_rsp.coef_out[0] = cur_byte[7 - (idx & 7)];
              end
              bit_ptr++;
              exp_rsp.bit_embedded = 1'b1;
            end else begin
              done = 1'b1;
            end
          end
          exp_rsp.embed_done = done;
          expected_coefs = {expected_coefs, exp_rsp};
        end
        default: ;
      endcase
    endfunction

    task check_result(rsp_t got);
      rsp_t want;
      if (expected_coefs.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat, coef_out %0d", got.coef_out));
      end else begin
        want = expected_coefs.pop_front();
        if (got.coef_out !== want.coef_out)
          report_mismatch($sformatf("coef_out %0d, expected %0d",
                                    got.coef_out, want.coef_out));
        if (got.bit_embedded !== want.bit_embedded)
          report_mismatch($sformatf("bit_embedded %b, expected %b",
                                    got.bit_embedded, want.bit_embedded));
        if (got.embed_done !== want.embed_done)
          report_mismatch($sformatf("embed_done %b, expected %b",
                                    got.embed_done, want.embed_done));
      end
    endtask

    task check_drained();
      if (expected_coefs.size() != 0)
        report_mismatch($sformatf("%0d result beats never arrived", expected_coefs.size()));
    endtask
  endclass

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             push        = 1'b0;
  logic             full;
  req_t             req_i       = '0;
  logic             empty;
  logic             pop         = 1'b0;
  rsp_t             rsp_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [LenW-1:0]  cfg_data_i  = '0;

  lsb_embed_tracker tracker = new();

  int items_sent = 0;
  int burst_left = 0;
  int rx_mode    = 0;
  int rx_left    = 0;

  dct_coefficient_lsb_embedder i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .req_i       (req_i),
    .empty       (empty),
    .pop         (pop),
    .rsp_o       (rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // Clock with a period of 20.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Input beat of the given kind with random content in every other field.
  function automatic req_t noise_item(logic [1:0] kind);
    logic [31:0] rnd_a;
    logic [31:0] rnd_b;
    req_t        r;
    rnd_a        = $urandom;
    rnd_b        = $urandom;
    r.req_type   = req_type_e'(kind);
    r.msg_addr   = rnd_a[11:0];
    r.msg_byte   = rnd_a[19:12];
    r.coef_pos   = rnd_a[25:20];
    r.coef_value = rnd_b[15:0];
    return r;
  endfunction

  // Sender pacing: bursts of random length, then a random gap.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Present one beat and hold it until the block takes it.
  task automatic send_item(req_t r);
    push  <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    tracker.note_input(r);
    if (r.req_type != ReqUnused) items_sent++;
    pace_sender();
  endtask

  task automatic send_load(logic [11:0] addr, logic [7:0] data);
    req_t r;
    r          = noise_item(ReqLoad);
    r.msg_addr = addr;
    r.msg_byte = data;
    send_item(r);
  endtask

  task automatic send_restart();
    send_item(noise_item(ReqRestart));
  endtask

  // A coefficient that would embed a never-loaded byte gets that byte first.
  task automatic send_coef(logic [5:0] pos, logic [15:0] value);
    req_t        r;
    int          need;
    logic [31:0] rnd;
    need = tracker.unloaded_byte();
    rnd  = $urandom;
    if (need >= 0 && pos != '0 && value != '0) send_load(need[11:0], rnd[7:0]);
    r            = noise_item(ReqCoef);
    r.coef_pos   = pos;
    r.coef_value = value;
    send_item(r);
  endtask

  // Length register write, only once every result beat has drained.
  task automatic write_length(logic [LenW-1:0] len);
    push <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (IdleCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= len;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    tracker.set_length(len);
    cfg_valid_i <= 1'b0;
  endtask

  // Result side: check every popped beat, pop on a changing stall pattern.
  always @(posedge clk_i) begin : result_sink
    if (rst_ni && pop && !empty) tracker.check_result(rsp_o);
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(40, 300);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0:       pop <= 1'b1;
      1:       pop <= ($urandom_range(0, 1) == 1);
      default: pop <= ($urandom_range(0, 11) == 0);
    endcase
  end

  // Stimulus: directed corners, then phases over several length settings.
  initial begin : stimulus
    req_t            r;
    logic [LenW-1:0] len_val;
    logic [31:0]     rnd;
    logic [31:0]     rnd2;
    logic [15:0]     cval;
    logic [5:0]      pos;
    int              roll;
    int              quota;
    int              stop_at;
    int              wait_cnt;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Dropped code with every field at its top value.
    r            = noise_item(ReqUnused);
    r.msg_addr   = '1;
    r.msg_byte   = '1;
    r.coef_pos   = '1;
    r.coef_value = '1;
    send_item(r);
    send_restart();
    send_load(12'hFFF, 8'hFF);
    send_load(12'h000, 8'h00);
    // DC and zero pass through; extremes and +/-1 take header bits.
    send_coef(6'd0, 16'h7FFF);
    send_coef(6'd5, 16'h0000);
    send_coef(6'd63, 16'h7FFF);
    send_coef(6'd1, 16'h8000);
    send_coef(6'd2, 16'h0001);
    send_coef(6'd3, 16'hFFFF);
    send_coef(6'd0, 16'h8000);
    send_coef(6'd63, 16'h0000);

    for (int phase = 0; phase < NumPhases; phase++) begin
      rnd = $urandom;
      case (phase)
        0:       len_val = '0;
        1:       len_val = 13'd1;
        2:       len_val = '1;
        3:       len_val = 13'd3;
        4:       len_val = 13'd4096;
        5:       len_val = 13'd2;
        6:       len_val = 13'd4097;
        7:       len_val = {9'd0, rnd[3:0]};
        8:       len_val = rnd[LenW-1:0];
        default: len_val = {10'd0, rnd[6:4]};
      endcase
      write_length(len_val);
      send_restart();
      // Short messages are loaded up front, as a real user would.
      if (len_val <= 16) begin
        for (int i = 0; i < int'(len_val); i++) begin
          rnd = $urandom;
          send_load(i[11:0], rnd[7:0]);
        end
      end

      quota   = (ItemTarget - items_sent) / (NumPhases - phase);
      stop_at = items_sent + quota;
      while (items_sent < stop_at) begin
        rnd  = $urandom;
        rnd2 = $urandom;
        roll = $urandom_range(0, 99);
        if (roll < 78) begin
          case ($urandom_range(0, 9))
            0:       cval = '0;
            1:       cval = rnd[0] ? 16'h0001 : 16'hFFFF;
            2:       cval = rnd[1] ? 16'h7FFF : 16'h8000;
            3, 4:    cval = {{12{rnd[4]}}, rnd[3:0]};
            default: cval = rnd[31:16];
          endcase
          pos = ($urandom_range(0, 9) == 0) ? 6'd0 : rnd2[5:0];
          send_coef(pos, cval);
        end else if (roll < 90) begin
          // Half of the loads rewrite the head of the message.
          if (rnd[31]) send_load({8'h00, rnd[3:0]}, rnd[15:8]);
          else         send_load(rnd[27:16], rnd[15:8]);
        end else if (roll < 94) begin
          send_restart();
        end else begin
          send_item(noise_item(ReqUnused));
        end
      end
    end

    // Drain the result side, then allow for the pipeline latency.
    push <= 1'b0;
    for (wait_cnt = 0; tracker.pending() != 0 && wait_cnt < DrainLimit; wait_cnt++)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    tracker.check_drained();
    if (tracker.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
